// ===== design/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsp_pkg: shared types, constants and the sine table for the scan converter
// Holds the field widths, register index codes and the Q1.14 quarter-wave
// sine table.
// ----------------------------------------------------------------------------
package lsp_pkg;

	localparam int MAX_BEAMS        = 4096;
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int ROM_IDX_W        = $clog2(SINE_TABLE_DEPTH);

	// Only the first quarter turn is stored; the other three are folded onto it.
	localparam int QTR_IDX_W         = ROM_IDX_W - 2;
	localparam int QUARTER_ROM_DEPTH = SINE_TABLE_DEPTH / 4;

	localparam int ANGLE_W    = 16;
	localparam int RANGE_W    = 16;
	localparam int COORD_W    = 18;
	localparam int BEAM_W     = 12;
	localparam int SINE_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Beam index saturates at the smaller of the scan length and the field range.
	localparam int BEAM_CAP     = ((MAX_BEAMS - 1) > 4095) ? 4095 : (MAX_BEAMS - 1);
	localparam int X_OFFSET_Q10 = 205;
	localparam int QUARTER_TURN = 16384;
	localparam int FULL_TURN    = 65536;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOWER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_UPPER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 2'd3;

	typedef struct packed {
		logic [RANGE_W-1:0] range_lower_limit;
		logic [RANGE_W-1:0] range_upper_limit;
		logic [ANGLE_W-1:0] start_angle;
		logic [ANGLE_W-1:0] angle_step;
	} cfg_t;

	typedef struct packed {
		logic [RANGE_W-1:0] range;
		logic [ANGLE_W-1:0] angle;
		logic [BEAM_W-1:0]  count;
	} beam_item_t;

	// Unsigned sine magnitudes of the first quarter turn, Q1.14.
	typedef logic [SINE_W-2:0] quarter_rom_t [QUARTER_ROM_DEPTH];

	// Polynomial sine over a quarter turn, t in [0, 16384], result in Q1.14.
	function automatic longint quarter_sine(input longint t);
		longint x2;
		longint inner;
		longint mid;
		x2    = (t * t) >>> 14;
		inner = 10512 - ((x2 * 1160) >>> 14);
		mid   = 25736 - ((x2 * inner) >>> 14);
		return (t * mid) >>> 14;
	endfunction

	function automatic quarter_rom_t build_quarter_rom();
		quarter_rom_t rom;
		for (int k = 0; k < QUARTER_ROM_DEPTH; k++)
			rom[k] = (SINE_W - 1)'(quarter_sine(longint'(k) * FULL_TURN / SINE_TABLE_DEPTH));
		return rom;
	endfunction

	localparam quarter_rom_t QUARTER_ROM = build_quarter_rom();

	// Sine at exactly a quarter turn, which falls just past the stored range.
	localparam logic [SINE_W-2:0] SINE_PEAK = (SINE_W - 1)'(quarter_sine(QUARTER_TURN));

endpackage

// ===== design/lsp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lsp_cfg_regs: configuration register file
// Four write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
module lsp_cfg_regs import lsp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_lower_limit <= '0;
			cfg_q.range_upper_limit <= '1;
			cfg_q.start_angle       <= '0;
			cfg_q.angle_step        <= ANGLE_W'(64);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RANGE_LOWER: cfg_q.range_lower_limit <= wr_data;
				REG_RANGE_UPPER: cfg_q.range_upper_limit <= wr_data;
				REG_START_ANGLE: cfg_q.start_angle       <= wr_data;
				REG_ANGLE_STEP:  cfg_q.angle_step        <= wr_data;
				default:         cfg_q                   <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/lsp_beam_track.sv =====
// ----------------------------------------------------------------------------
// lsp_beam_track: beam angle and index tracking plus the input register
// Advances the angle and index on every accepted sample, applies the range
// filter and holds surviving samples in the first pipeline stage.
// ----------------------------------------------------------------------------
module lsp_beam_track import lsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_fire,
	input  logic [RANGE_W-1:0] range_sample,
	input  logic               scan_start,
	input  logic               stage_adv,
	output logic               keep,
	output logic               valid_s1,
	output beam_item_t         item_s1
);

	logic [ANGLE_W-1:0] beam_angle_q;
	logic [BEAM_W-1:0]  beam_count_q;
	logic [ANGLE_W-1:0] angle_next;
	logic [BEAM_W-1:0]  count_next;

	always_comb begin
		if (scan_start) begin
			angle_next = cfg.start_angle;
			count_next = '0;
		end else begin
			angle_next = beam_angle_q + cfg.angle_step;
			count_next = (beam_count_q < BEAM_W'(BEAM_CAP)) ? beam_count_q + 1'b1
			                                                 : beam_count_q;
		end
	end

	// Inverted limits are applied as written and may drop every sample.
	assign keep = (range_sample > cfg.range_lower_limit) &&
	              (range_sample < cfg.range_upper_limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_angle_q <= '0;
			beam_count_q <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (in_fire) begin
				beam_angle_q <= angle_next;
				beam_count_q <= count_next;
				valid_s1     <= keep;
			end else if (stage_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && keep) begin
			item_s1.range <= range_sample;
			item_s1.angle <= angle_next;
			item_s1.count <= count_next;
		end
	end

endmodule

// ===== design/lsp_rotate.sv =====
// ----------------------------------------------------------------------------
// lsp_rotate: polar to Cartesian rotation
// Looks up sine and cosine of the beam angle in a quarter-wave table, scales
// the range by each with round-half-up, and adds the sensor x offset.
// ----------------------------------------------------------------------------
module lsp_rotate import lsp_pkg::*; (
	input  beam_item_t                 item,
	output logic signed [COORD_W-1:0]  x,
	output logic signed [COORD_W-1:0]  y
);

	localparam int PROD_W = RANGE_W + 1 + SINE_W;

	logic [ANGLE_W-1:0]       cos_angle;
	logic [ROM_IDX_W-1:0]     sin_idx;
	logic [ROM_IDX_W-1:0]     cos_idx;
	logic signed [SINE_W-1:0] sin_val;
	logic signed [SINE_W-1:0] cos_val;
	logic signed [PROD_W-1:0] prod_x;
	logic signed [PROD_W-1:0] prod_y;
	logic signed [PROD_W:0]   round_x;
	logic signed [PROD_W:0]   round_y;

	// Odd quadrants mirror the quarter-wave index, the upper half negates.
	function automatic logic signed [SINE_W-1:0] rom_sine(input logic [ROM_IDX_W-1:0] idx);
		logic [QTR_IDX_W:0] qidx;
		logic [SINE_W-2:0]  mag;
		qidx = {1'b0, idx[QTR_IDX_W-1:0]};
		if (idx[QTR_IDX_W])
			qidx = (QTR_IDX_W + 1)'(QUARTER_ROM_DEPTH) - qidx;
		mag = qidx[QTR_IDX_W] ? SINE_PEAK : QUARTER_ROM[qidx[QTR_IDX_W-1:0]];
		return idx[ROM_IDX_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	assign cos_angle = item.angle + ANGLE_W'(QUARTER_TURN);
	assign sin_idx   = item.angle[ANGLE_W-1 -: ROM_IDX_W];
	assign cos_idx   = cos_angle[ANGLE_W-1 -: ROM_IDX_W];
	assign sin_val   = rom_sine(sin_idx);
	assign cos_val   = rom_sine(cos_idx);

	assign prod_x = $signed({1'b0, item.range}) * cos_val;
	assign prod_y = $signed({1'b0, item.range}) * sin_val;

	// Add half an LSB of Q14, then floor: halves round toward plus infinity.
	assign round_x = (PROD_W + 1)'(prod_x) + (PROD_W + 1)'(8192);
	assign round_y = (PROD_W + 1)'(prod_y) + (PROD_W + 1)'(8192);

	assign x = COORD_W'(round_x >>> 14) + COORD_W'(X_OFFSET_Q10);
	assign y = COORD_W'(round_y >>> 14);

endmodule

// ===== design/lidar_scan_to_points.sv =====
// ----------------------------------------------------------------------------
// lidar_scan_to_points: lidar range samples to sensor-frame Cartesian points
// Input channel (in_valid/in_ready) carries range_sample (Q6.10 m) and
// scan_start. Output channel (out_valid/out_ready) carries point_x, point_y
// (signed Q7.10 m) and beam_number. Registers are loaded from wr_en,
// wr_index and wr_data; the user must load them only while the block is idle,
// as the block itself does not enforce it. A sample transfer lands in the
// input register; when the output register is free, the rotation result
// moves into the output register, which offers the point. Throughput is one
// sample per cycle while the receiver keeps taking points, set by the single
// lookup-and-multiply stage between the two registers.
// Samples outside the range window advance the beam state and give no point.
// Reset clears the angle, the index, both valid flags and the registers to
// their defaults. When the receiver stalls, the output holds, the input
// register fills, and in_ready drops until the output is taken.
// ----------------------------------------------------------------------------
module lidar_scan_to_points import lsp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [CFG_IDX_W-1:0]       wr_index,
	input  logic [CFG_DATA_W-1:0]      wr_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [RANGE_W-1:0]         range_sample,
	input  logic                       scan_start,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [COORD_W-1:0]  point_x,
	output logic signed [COORD_W-1:0]  point_y,
	output logic [BEAM_W-1:0]          beam_number
);

	cfg_t                      cfg;
	beam_item_t                item_s1;
	logic                      valid_s1;
	logic                      keep;
	logic                      in_fire;
	logic                      out_free;
	logic                      stage_adv;
	logic signed [COORD_W-1:0] x_calc;
	logic signed [COORD_W-1:0] y_calc;
	logic                      out_valid_q;
	logic signed [COORD_W-1:0] point_x_q;
	logic signed [COORD_W-1:0] point_y_q;
	logic [BEAM_W-1:0]         beam_number_q;

	// The output register can load when empty or when its point is being taken.
	assign out_free  = !out_valid_q || out_ready;
	assign stage_adv = valid_s1 && out_free;
	// The input register frees up in the same cycle that it moves forward.
	assign in_ready  = !valid_s1 || out_free;
	assign in_fire   = in_valid && in_ready;

	lsp_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	lsp_beam_track u_beam_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_fire      (in_fire),
		.range_sample (range_sample),
		.scan_start   (scan_start),
		.stage_adv    (stage_adv),
		.keep         (keep),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1)
	);

	lsp_rotate u_rotate (
		.item (item_s1),
		.x    (x_calc),
		.y    (y_calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_adv) begin
			point_x_q     <= x_calc;
			point_y_q     <= y_calc;
			beam_number_q <= item_s1.count;
		end
	end

	assign out_valid   = out_valid_q;
	assign point_x     = point_x_q;
	assign point_y     = point_y_q;
	assign beam_number = beam_number_q;

`ifndef ASSERT_OFF
	// A sample that passes the range window always occupies the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && keep |=> valid_s1)
		else $error("kept sample did not reach the input register");

	// A filtered sample never creates an input register entry by itself.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !keep |=> !valid_s1)
		else $error("filtered sample entered the input register");

	// A blocked input register keeps its entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1)
		else $error("input register lost an entry while blocked");

	// An entry that moves forward shows up on the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		stage_adv |=> out_valid)
		else $error("advanced entry missing from output register");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the lidar scan-to-points converter
// Sends range samples grouped into scans, predicts every point from its own
// copy of the beam state, the range window and a quarter-wave sine
// polynomial, and checks each output transfer field by field against the
// oldest pending prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import lsp_pkg::*;

	// One predicted point, in the same widths as the output ports.
	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [BEAM_W-1:0]         beam;
	} point_t;

	// How the receiver paces out_ready when it is not in a long hold-off.
	typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      wr_en;
	logic [CFG_IDX_W-1:0]      wr_index;
	logic [CFG_DATA_W-1:0]     wr_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [RANGE_W-1:0]        range_sample;
	logic                      scan_start;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic [BEAM_W-1:0]         beam_number;

	lidar_scan_to_points u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.range_sample (range_sample),
		.scan_start   (scan_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_x      (point_x),
		.point_y      (point_y),
		.beam_number  (beam_number)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The run is bounded well above the slowest legal schedule of all tests.
	initial begin
		#2_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor state: the bench's own copy of the registers and beam state.
	// ------------------------------------------------------------------------
	logic [RANGE_W-1:0] cfg_lower;
	logic [RANGE_W-1:0] cfg_upper;
	logic [ANGLE_W-1:0] cfg_start;
	logic [ANGLE_W-1:0] cfg_step;
	logic [ANGLE_W-1:0] beam_ang;
	logic [BEAM_W-1:0]  beam_idx;

	point_t pending_points[$];
	int     fault_count;

	// Sender pacing: bursts of transfers separated by random gaps.
	int burst_left;
	bit gaps_on;

	// Receiver pacing. A hold-off is requested by bumping hold_seq; the
	// receiver notices the change and counts the stall down on its own.
	rx_mode_e rx_mode = RX_ALWAYS;
	int       hold_seq = 0;
	int       hold_len = 0;
	int       hold_seen = 0;
	int       hold_left = 0;
	int       rx_phase = 0;
	point_t   want;

	function automatic void log_fault(input string msg);
		if (fault_count < 10)
			$display("%0t ns: %s", $realtime, msg);
		fault_count++;
	endfunction

	// Quarter-wave sine polynomial in Q1.14; t runs over [0, a quarter turn].
	function automatic int poly_quarter(input longint t);
		longint sq;
		longint inner;
		longint outer;
		sq    = (t * t) >>> 14;
		inner = 10512 - ((sq * 1160) >>> 14);
		outer = 25736 - ((sq * inner) >>> 14);
		return int'((t * outer) >>> 14);
	endfunction

	// Sine as the table gives it: the angle is first snapped down to the
	// start of its table slot, then folded into the first quadrant.
	function automatic int table_sine(input logic [ANGLE_W-1:0] ang);
		longint             slot;
		longint             base;
		logic [ANGLE_W-1:0] snapped;
		int                 mag;
		slot    = (longint'(ang) * SINE_TABLE_DEPTH) >>> 16;
		base    = (slot * FULL_TURN) / SINE_TABLE_DEPTH;
		snapped = base[ANGLE_W-1:0];
		mag     = snapped[14] ? poly_quarter(QUARTER_TURN - snapped[13:0])
		                      : poly_quarter(snapped[13:0]);
		return snapped[15] ? -mag : mag;
	endfunction

	// Advances the beam state for one accepted sample and queues the point,
	// unless the range falls outside the open window (lower, upper).
	function automatic void predict_point(input logic [RANGE_W-1:0] rng,
	                                      input logic first);
		int     sin_v;
		int     cos_v;
		longint px;
		longint py;
		point_t pt;
		if (first) begin
			beam_ang = cfg_start;
			beam_idx = '0;
		end else begin
			beam_ang = beam_ang + cfg_step;
			if (beam_idx < BEAM_CAP)
				beam_idx = beam_idx + 1'b1;
		end
		if (rng <= cfg_lower || rng >= cfg_upper)
			return;
		sin_v = table_sine(beam_ang);
		cos_v = table_sine(beam_ang + ANGLE_W'(QUARTER_TURN));
		// Halves round up: add half an LSB, then take the floor.
		px = ((longint'(rng) * cos_v + 8192) >>> 14) + X_OFFSET_Q10;
		py = (longint'(rng) * sin_v + 8192) >>> 14;
		pt.x    = px[COORD_W-1:0];
		pt.y    = py[COORD_W-1:0];
		pt.beam = beam_idx;
		pending_points = {pending_points, pt};
	endfunction

	// ------------------------------------------------------------------------
	// Receiver and checker. Outputs are sampled at the edge, before the
	// block's own updates land, and out_ready is driven for the next edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				log_fault($sformatf("unexpected point x=%0d y=%0d beam=%0d",
					point_x, point_y, beam_number));
			end else begin
				want = pending_points.pop_front();
				if (point_x !== want.x || point_y !== want.y || beam_number !== want.beam)
					log_fault($sformatf("point mismatch: exp x=%0d y=%0d beam=%0d, got x=%0d y=%0d beam=%0d",
						want.x, want.y, want.beam, point_x, point_y, beam_number));
			end
		end
		rx_phase++;
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: out_ready <= 1'b1;
				RX_RANDOM: out_ready <= ($urandom_range(0, 99) < 55);
				default:   out_ready <= ((rx_phase % 7) != 2) && ((rx_phase % 7) != 5);
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Shared stimulus tasks.
	// ------------------------------------------------------------------------

	// Writes all four registers on back-to-back edges; only called while idle.
	task automatic set_config(input logic [RANGE_W-1:0] lower,
	                          input logic [RANGE_W-1:0] upper,
	                          input logic [ANGLE_W-1:0] start,
	                          input logic [ANGLE_W-1:0] step);
		wr_en    <= 1'b1;
		wr_index <= REG_RANGE_LOWER;
		wr_data  <= lower;
		@(posedge clk);
		wr_index <= REG_RANGE_UPPER;
		wr_data  <= upper;
		@(posedge clk);
		wr_index <= REG_START_ANGLE;
		wr_data  <= start;
		@(posedge clk);
		wr_index <= REG_ANGLE_STEP;
		wr_data  <= step;
		@(posedge clk);
		wr_en <= 1'b0;
		cfg_lower = lower;
		cfg_upper = upper;
		cfg_start = start;
		cfg_step  = step;
	endtask

	// Offers one sample and returns at the edge where it transfers. Valid is
	// only lowered at the start of a gap, so back-to-back samples keep it high.
	task automatic send_sample(input logic [RANGE_W-1:0] rng, input logic first);
		int gap;
		if (burst_left == 0) begin
			gap        = gaps_on ? $urandom_range(0, 6) : 0;
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid     <= 1'b1;
		range_sample <= rng;
		scan_start   <= first;
		do @(posedge clk); while (!in_ready);
		predict_point(rng, first);
		burst_left--;
	endtask

	// Waits until every predicted point has arrived. Filtered samples leave
	// nothing to wait for, so it also waits out the two-stage pipeline.
	task automatic drain;
		in_valid   <= 1'b0;
		burst_left = 0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Picks a range that mostly lands inside the current window, with some
	// fully random values and the two extremes mixed in.
	function automatic logic [RANGE_W-1:0] pick_range();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return RANGE_W'($urandom);
		if (pick < 14)
			return ($urandom_range(0, 1) != 0) ? {RANGE_W{1'b1}} : '0;
		if (int'(cfg_lower) + 1 < int'(cfg_upper))
			return RANGE_W'($urandom_range(int'(cfg_lower) + 1, int'(cfg_upper) - 1));
		return RANGE_W'($urandom);
	endfunction

	// ------------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------------

	// Right after reset no scan has started, so the first samples continue
	// from angle zero and index zero. Zero and full-scale ranges are dropped
	// by the default window.
	task automatic test_no_start_seen;
		gaps_on = 1'b0;
		rx_mode = RX_ALWAYS;
		send_sample(16'd1024, 1'b0);
		send_sample(16'd0, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'hFFFE, 1'b0);
		send_sample(16'd1, 1'b0);
		drain();
	endtask

	// The window is open at both ends: samples equal to either limit are
	// dropped. Inverted and empty windows drop everything, yet the beam
	// state must keep moving.
	task automatic test_range_window;
		set_config(16'd1000, 16'd2000, 16'd0, 16'd4096);
		send_sample(16'd1000, 1'b1);
		send_sample(16'd1001, 1'b0);
		send_sample(16'd1999, 1'b0);
		send_sample(16'd2000, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		drain();
		set_config(16'd3000, 16'd100, 16'd0, 16'd4096);
		send_sample(16'd2000, 1'b0);
		send_sample(16'd50, 1'b0);
		send_sample(16'd5000, 1'b0);
		drain();
		set_config(16'd0, 16'd0, 16'd0, 16'd4096);
		send_sample(16'd1, 1'b0);
		drain();
	endtask

	// Most negative and most positive start angles and steps, and a step of
	// exactly a quarter turn so that every quadrant boundary is hit, some at
	// the largest range the window lets through.
	task automatic test_angle_extremes;
		set_config(16'd0, 16'hFFFF, 16'h8000, 16'h7FFF);
		send_sample(16'hFFFE, 1'b1);
		send_sample(16'hFFFE, 1'b0);
		send_sample(16'd12345, 1'b0);
		drain();
		set_config(16'd0, 16'hFFFF, 16'h7FFF, 16'h8000);
		send_sample(16'hFFFE, 1'b1);
		send_sample(16'hFFFE, 1'b0);
		drain();
		set_config(16'd0, 16'hFFFF, 16'd0, 16'd16384);
		for (int i = 0; i < 5; i++)
			send_sample(16'd40000, (i == 0));
		drain();
	endtask

	// A longer scan whose step carries the angle past a full turn partway
	// through. Some beams are filtered, and the index must still count them.
	task automatic test_long_scan;
		gaps_on = 1'b0;
		rx_mode = RX_ALWAYS;
		set_config(16'd0, 16'hFFFF, 16'd100, 16'd1100);
		for (int i = 0; i < 64; i++) begin
			if (i % 5 == 3)
				send_sample(16'd0, 1'b0);
			else
				send_sample(16'd3000 + 16'(i), (i == 0));
		end
		drain();
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering, so the output register and then the input register fill and
	// in_ready has to drop until the stall is released.
	task automatic test_backpressure;
		gaps_on = 1'b0;
		rx_mode = RX_ALWAYS;
		set_config(16'd0, 16'hFFFF, 16'hC000, 16'd321);
		hold_len <= 80;
		hold_seq <= hold_seq + 1;
		for (int i = 0; i < 40; i++)
			send_sample(RANGE_W'($urandom_range(1, 65534)), (i == 0));
		drain();
	endtask

	// Random scans under several settings. Phases 0 and 1 pin the angle
	// registers at their extremes; the others draw them at random with a
	// window wide enough to keep points flowing. Some samples raise the
	// scan flag mid-scan to break sequences up.
	task automatic test_random_scans;
		logic [RANGE_W-1:0] lower;
		logic [RANGE_W-1:0] upper;
		logic [ANGLE_W-1:0] start;
		logic [ANGLE_W-1:0] step;
		int                 sent;
		int                 scan_len;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					lower = '0;
					upper = '1;
					start = 16'h8000;
					step  = 16'h7FFF;
				end
				1: begin
					lower = '0;
					upper = '1;
					start = 16'h7FFF;
					step  = 16'h8000;
				end
				default: begin
					lower = RANGE_W'($urandom_range(0, 20000));
					upper = RANGE_W'($urandom_range(30000, 65535));
					start = ANGLE_W'($urandom);
					case ($urandom_range(0, 5))
						0:       step = 16'd0;
						1:       step = 16'd1;
						2:       step = 16'hFFFF;
						default: step = ANGLE_W'($urandom);
					endcase
				end
			endcase
			set_config(lower, upper, start, step);
			gaps_on = (phase % 3 != 0);
			case (phase % 3)
				0:       rx_mode = RX_RANDOM;
				1:       rx_mode = RX_PATTERN;
				default: rx_mode = ($urandom_range(0, 1) != 0) ? RX_ALWAYS : RX_RANDOM;
			endcase
			sent = 0;
			while (sent < 40) begin
				scan_len = $urandom_range(1, 40);
				for (int b = 0; b < scan_len; b++) begin
					send_sample(pick_range(), (b == 0) || ($urandom_range(0, 99) < 4));
					sent++;
				end
			end
			drain();
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		wr_en        = 1'b0;
		wr_index     = REG_RANGE_LOWER;
		wr_data      = '0;
		in_valid     = 1'b0;
		range_sample = '0;
		scan_start   = 1'b0;
		fault_count  = 0;
		burst_left   = 0;
		gaps_on      = 1'b0;
		// Predictor starts from the reset values of the block.
		cfg_lower = '0;
		cfg_upper = '1;
		cfg_start = '0;
		cfg_step  = 16'd64;
		beam_ang  = '0;
		beam_idx  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_no_start_seen();
		test_range_window();
		test_angle_extremes();
		test_long_scan();
		test_backpressure();
		test_random_scans();

		repeat (10) @(posedge clk);
		if (pending_points.size() != 0)
			log_fault($sformatf("%0d points never arrived", pending_points.size()));
		if (fault_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
